/* rtl/core/overlap_add_hann_synthesis_assert.svh */
`ifndef OVERLAP_ADD_HANN_SYNTHESIS_ASSERT_SVH
`define OVERLAP_ADD_HANN_SYNTHESIS_ASSERT_SVH

// Shared assertion forms. Each use expects clk and arst_n in scope.

`define OAHS_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`define OAHS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define OAHS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/oahs_pkg.sv */
`timescale 1ns / 1ps

package oahs_pkg;

	localparam int HALF_FRAME = 128;
	localparam int CHANNELS   = 2;
	localparam int N_OUT      = 4;
	localparam int FRAME      = 2 * HALF_FRAME;
	localparam int POS_W      = $clog2(FRAME);
	localparam int ADDR_W     = $clog2(HALF_FRAME);

	localparam int SAMPLE_W = 16;
	localparam int WIN_W    = 16;
	localparam int TAIL_W   = 32;
	localparam int DAC_W    = 16;
	localparam int PROD_W   = SAMPLE_W + WIN_W + 1;
	localparam int SCALE_W  = DAC_W + 1;
	localparam int NUM_W    = TAIL_W + SCALE_W;

	localparam logic [DAC_W-1:0] MID_RESET = 16'd2048;

	localparam logic [63:0] PI_Q30   = 64'd3373259426;
	localparam logic [63:0] ONE_Q30  = 64'd1073741824;
	localparam logic [63:0] HALF_U64 = 64'(HALF_FRAME);
	localparam logic [63:0] SERIES_DIV [12] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
		64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
	};

	typedef logic [WIN_W-1:0] hann_rom_t [FRAME];

	typedef struct packed {
		logic                      accept;
		logic [ADDR_W-1:0]         rd_addr;
		logic [WIN_W-1:0]          weight;
		logic                      tail_ok;
		logic                      ld_s2;
		logic                      ld_s3;
		logic                      wr_en;
		logic [ADDR_W-1:0]         wr_addr;
		logic                      ld_s4;
		logic signed [SCALE_W-1:0] scale;
		logic [DAC_W-1:0]          mid;
	} lane_ctrl_t;

	// Q16 raised-cosine value for the first quarter of the frame.
	function automatic logic [63:0] hann_series(input logic [63:0] x);
		logic [63:0]        a;
		logic [63:0]        a2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		a    = (PI_Q30 * x) / HALF_U64;
		a2   = (a * a) >> 30;
		term = ONE_Q30;
		sum  = $signed(ONE_Q30);
		for (int n = 1; n <= 12; n++) begin
			term = ((term * a2) >> 30) / SERIES_DIV[n-1];
			if ((n % 2) == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > $signed(ONE_Q30)) begin
			sum = $signed(ONE_Q30);
		end
		return ((ONE_Q30 - 64'(sum)) + 64'd16384) >> 15;
	endfunction

	function automatic logic [63:0] hann_value(input logic [63:0] xin);
		logic [63:0] x;
		x = xin;
		if (x > HALF_U64) begin
			x = 2 * HALF_U64 - x;
		end
		if (2 * x <= HALF_U64) begin
			return hann_series(x);
		end
		return 64'd65536 - hann_series(HALF_U64 - x);
	endfunction

	function automatic hann_rom_t hann_rom_build();
		hann_rom_t   rom;
		logic [63:0] w;
		for (int x = 0; x < FRAME; x++) begin
			w = hann_value(64'(x));
			rom[x] = (w > 64'd65535) ? 16'hFFFF : w[WIN_W-1:0];
		end
		return rom;
	endfunction

	localparam hann_rom_t HANN_ROM = hann_rom_build();

endpackage

/* rtl/core/oahs_ram.sv */
`timescale 1ns / 1ps

module oahs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/core/oahs_lane.sv */
`timescale 1ns / 1ps

module oahs_lane (
	input  logic                                    clk,
	input  oahs_pkg::lane_ctrl_t                    ctrl,
	input  logic signed [oahs_pkg::SAMPLE_W-1:0]    sample,
	output logic [oahs_pkg::DAC_W-1:0]              dac
);

	logic signed [oahs_pkg::SAMPLE_W-1:0] sample_s1;
	logic [oahs_pkg::TAIL_W-1:0]          rd_data;
	logic signed [oahs_pkg::TAIL_W-1:0]   tail_s2;
	logic signed [oahs_pkg::PROD_W-1:0]   prod_s2;
	logic signed [oahs_pkg::PROD_W-1:0]   prod_c;
	logic signed [oahs_pkg::TAIL_W+1:0]   sum_c;
	logic signed [oahs_pkg::TAIL_W-1:0]   acc_c;
	logic signed [oahs_pkg::TAIL_W-1:0]   acc_s3;
	logic signed [oahs_pkg::NUM_W-1:0]    num_c;
	logic signed [oahs_pkg::NUM_W-1:0]    num_s4;
	logic signed [oahs_pkg::NUM_W:0]      round_c;

	oahs_ram #(
		.WIDTH(oahs_pkg::TAIL_W),
		.DEPTH(oahs_pkg::HALF_FRAME)
	) u_tail (
		.clk    (clk),
		.wr_en  (ctrl.wr_en),
		.wr_addr(ctrl.wr_addr),
		.wr_data(prod_s2[oahs_pkg::TAIL_W-1:0]),
		.rd_en  (ctrl.accept),
		.rd_addr(ctrl.rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		prod_c = $signed(sample_s1) * $signed({1'b0, ctrl.weight});
		sum_c  = {{2{tail_s2[oahs_pkg::TAIL_W-1]}}, tail_s2}
			+ {prod_s2[oahs_pkg::PROD_W-1], prod_s2};
		if (sum_c[oahs_pkg::TAIL_W+1:oahs_pkg::TAIL_W-1]
				!= {3{sum_c[oahs_pkg::TAIL_W+1]}}) begin
			acc_c = sum_c[oahs_pkg::TAIL_W+1] ? {1'b1, {(oahs_pkg::TAIL_W-1){1'b0}}}
				: {1'b0, {(oahs_pkg::TAIL_W-1){1'b1}}};
		end else begin
			acc_c = sum_c[oahs_pkg::TAIL_W-1:0];
		end
		num_c = acc_s3 * ctrl.scale;
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			sample_s1 <= sample;
		end
		if (ctrl.ld_s2) begin
			tail_s2 <= ctrl.tail_ok ? $signed(rd_data) : '0;
			prod_s2 <= prod_c;
		end
		if (ctrl.ld_s3) begin
			acc_s3 <= acc_c;
		end
		if (ctrl.ld_s4) begin
			num_s4 <= num_c;
		end
	end

	// Adds the midpoint offset and half an output step, then rounds and clamps.
	always_comb begin
		round_c = {num_s4[oahs_pkg::NUM_W-1], num_s4}
			+ $signed({3'b000, ctrl.mid, 1'b1, 30'd0});
		if (round_c[oahs_pkg::NUM_W]) begin
			dac = '0;
		end else if (|round_c[oahs_pkg::NUM_W-1:47]) begin
			dac = '1;
		end else begin
			dac = round_c[46:31];
		end
	end

endmodule

/* rtl/core/overlap_add_hann_synthesis.sv */
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// in        in_valid / in_stall     sample_0 .. sample_3 (signed Q1.15)
// out       out_valid / out_stall   dac_0 .. dac_3 (unsigned DAC codes)
// config    cfg_write               cfg_data (DAC midpoint)
//
// An item passes four lane stages: window and tail read, product, sum, DAC scaling.
// A new item is taken once stages one to three are empty; a result loads from the last stage.
// Only one item is in the lanes at a time, set by the four-stage lane pipeline.
// After reset the tail store reads as zero until the first second-half item writes it.
// A result waiting in the output register does not block the next item; an emitting
// item waits in the last stage while the output register is full and stalled.

`include "overlap_add_hann_synthesis_assert.svh"

module overlap_add_hann_synthesis (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [oahs_pkg::DAC_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [oahs_pkg::SAMPLE_W-1:0] sample_0,
	input  logic signed [oahs_pkg::SAMPLE_W-1:0] sample_1,
	input  logic signed [oahs_pkg::SAMPLE_W-1:0] sample_2,
	input  logic signed [oahs_pkg::SAMPLE_W-1:0] sample_3,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [oahs_pkg::DAC_W-1:0]           dac_0,
	output logic [oahs_pkg::DAC_W-1:0]           dac_1,
	output logic [oahs_pkg::DAC_W-1:0]           dac_2,
	output logic [oahs_pkg::DAC_W-1:0]           dac_3
);

	logic [oahs_pkg::POS_W-1:0]           pos_q;
	logic [oahs_pkg::DAC_W-1:0]           mid_q;
	logic                                 filled_q;
	logic                                 out_valid_q;
	logic [oahs_pkg::DAC_W-1:0]           dac_q [oahs_pkg::N_OUT];

	logic                                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic                                 emit_s1, emit_s2, emit_s3, emit_s4;
	logic [oahs_pkg::ADDR_W-1:0]          slot_s1, slot_s2;
	logic [oahs_pkg::WIN_W-1:0]           weight_s1;

	logic                                 in_acc;
	logic                                 out_acc;
	logic                                 emit_c;
	logic [oahs_pkg::ADDR_W-1:0]          slot_c;
	logic                                 blocked;
	logic                                 out_load;
	oahs_pkg::lane_ctrl_t                 ctrl;
	logic signed [oahs_pkg::SAMPLE_W-1:0] samples [oahs_pkg::N_OUT];
	logic [oahs_pkg::DAC_W-1:0]           lane_dac [oahs_pkg::N_OUT];

	assign samples[0] = sample_0;
	assign samples[1] = sample_1;
	assign samples[2] = sample_2;
	assign samples[3] = sample_3;

	assign emit_c = pos_q < oahs_pkg::POS_W'(oahs_pkg::HALF_FRAME);
	assign slot_c = emit_c ? oahs_pkg::ADDR_W'(pos_q)
		: oahs_pkg::ADDR_W'(pos_q - oahs_pkg::POS_W'(oahs_pkg::HALF_FRAME));

	assign blocked  = valid_s4 && emit_s4 && out_valid_q && out_stall;
	assign out_load = valid_s4 && emit_s4 && !blocked;
	assign in_stall = valid_s1 || valid_s2 || valid_s3 || blocked;
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;

	always_comb begin
		ctrl.accept  = in_acc;
		ctrl.rd_addr = slot_c;
		ctrl.weight  = weight_s1;
		ctrl.tail_ok = filled_q;
		ctrl.ld_s2   = valid_s1;
		ctrl.ld_s3   = valid_s2;
		ctrl.wr_en   = valid_s2 && !emit_s2;
		ctrl.wr_addr = slot_s2;
		ctrl.ld_s4   = valid_s3;
		ctrl.scale   = $signed({1'b0, mid_q}) - 17'sd1;
		ctrl.mid     = mid_q;
	end

	for (genvar c = 0; c < oahs_pkg::N_OUT; c++) begin : g_lane
		if (c < oahs_pkg::CHANNELS) begin : g_on
			oahs_lane u_lane (
				.clk   (clk),
				.ctrl  (ctrl),
				.sample(samples[c]),
				.dac   (lane_dac[c])
			);
		end else begin : g_off
			assign lane_dac[c] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			mid_q       <= oahs_pkg::MID_RESET;
			filled_q    <= 1'b0;
			out_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
		end else begin
			if (cfg_write) begin
				mid_q <= cfg_data;
			end
			if (in_acc) begin
				pos_q <= (pos_q == oahs_pkg::POS_W'(oahs_pkg::FRAME - 1)) ? '0
					: pos_q + 1'b1;
			end
			if (ctrl.wr_en) begin
				filled_q <= 1'b1;
			end
			valid_s1 <= in_acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3 || blocked;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			emit_s1   <= emit_c;
			slot_s1   <= slot_c;
			weight_s1 <= oahs_pkg::HANN_ROM[pos_q];
		end
		if (valid_s1) begin
			emit_s2 <= emit_s1;
			slot_s2 <= slot_s1;
		end
		if (valid_s2) begin
			emit_s3 <= emit_s2;
		end
		if (valid_s3) begin
			emit_s4 <= emit_s3;
		end
		if (out_load) begin
			for (int c = 0; c < oahs_pkg::N_OUT; c++) begin
				dac_q[c] <= lane_dac[c];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign dac_0     = dac_q[0];
	assign dac_1     = dac_q[1];
	assign dac_2     = dac_q[2];
	assign dac_3     = dac_q[3];

	`OAHS_ASSERT_ALWAYS(a_one_in_flight, $onehot0({valid_s1, valid_s2, valid_s3, valid_s4}),
		"more than one item in the lanes")
	`OAHS_ASSERT_NEXT(a_accept_enters, in_acc, valid_s1, "accepted item did not enter stage one")
	`OAHS_ASSERT_NEXT(a_pos_wraps, in_acc && pos_q == oahs_pkg::POS_W'(oahs_pkg::FRAME - 1),
		pos_q == '0, "frame position did not wrap")
	`OAHS_ASSERT_NEXT(a_result_lands, out_load, out_valid_q, "finished item did not reach output")
	`OAHS_ASSERT_SAME(a_no_write_when_emit, valid_s2 && emit_s2, !ctrl.wr_en,
		"tail written during the first half of a frame")

endmodule

/* tb/sv/overlap_add_hann_synthesis_tb.sv */
`timescale 1ns / 1ps

module overlap_add_hann_synthesis_tb;

	import oahs_pkg::*;

	typedef logic [N_OUT-1:0][DAC_W-1:0]    dac_word_t;
	typedef logic [N_OUT-1:0][SAMPLE_W-1:0] sample_word_t;

	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned PHASE_ITEMS = 180;
	localparam int unsigned SETTLE_CYCLES = 12;

	localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [6] = '{
		16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h4000
	};

	// Overlap-add of Hann-weighted samples, scaled to DAC codes.
	class hann_ola_predictor;
		logic [WIN_W-1:0] window [FRAME];
		int               tail [CHANNELS][HALF_FRAME];
		int unsigned      position;
		logic [DAC_W-1:0] midpoint;
		dac_word_t        expected_codes [$];
		int unsigned      faults;

		function new();
			longint unsigned w;
			for (int x = 0; x < FRAME; x++) begin
				w = raised_cosine(longint'(x));
				window[x] = (w > 64'd65535) ? 16'hFFFF : w[WIN_W-1:0];
			end
			foreach (tail[c, s]) tail[c][s] = 0;
			position = 0;
			midpoint = 16'd2048;
			faults = 0;
		endfunction

		// Quarter-wave Q16 value from a truncated Q30 cosine series.
		function longint unsigned cosine_q16(longint unsigned x);
			longint unsigned angle;
			longint unsigned angle_sq;
			longint unsigned term;
			longint          sum;
			angle = (64'd3373259426 * x) / longint'(HALF_FRAME);
			angle_sq = (angle * angle) >> 30;
			term = 64'd1073741824;
			sum = 64'sd1073741824;
			for (int n = 1; n <= 12; n++) begin
				term = ((term * angle_sq) >> 30) / longint'((2 * n - 1) * (2 * n));
				if (n % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > 64'sd1073741824) begin
				sum = 64'sd1073741824;
			end
			return (64'd1073741824 - longint'(sum) + 64'd16384) >> 15;
		endfunction

		function longint unsigned raised_cosine(longint unsigned xin);
			longint unsigned x;
			x = xin;
			if (x > HALF_FRAME) begin
				x = 2 * HALF_FRAME - x;
			end
			if (2 * x <= HALF_FRAME) begin
				return cosine_q16(x);
			end
			return 64'd65536 - cosine_q16(HALF_FRAME - x);
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) begin
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				return -64'sd2147483648;
			end
			return v;
		endfunction

		function logic [DAC_W-1:0] dac_code(longint acc);
			longint m;
			longint num;
			longint r;
			m = longint'(midpoint);
			num = acc * (m - 1) + m * 64'sd2147483648;
			if (num >= 0) begin
				r = (num + 64'sd1073741824) >>> 31;
			end else begin
				r = -((-num + 64'sd1073741824) >>> 31);
			end
			if (r < 0) begin
				r = 0;
			end
			if (r > 65535) begin
				r = 65535;
			end
			return r[DAC_W-1:0];
		endfunction

		function void set_midpoint(logic [DAC_W-1:0] value);
			midpoint = value;
		endfunction

		function void take_samples(sample_word_t s);
			longint    w;
			longint    prod;
			dac_word_t codes;
			w = longint'(window[position]);
			if (position < HALF_FRAME) begin
				codes = '0;
				for (int c = 0; c < CHANNELS; c++) begin
					prod = longint'($signed(s[c])) * w;
					codes[c] = dac_code(clamp32(longint'(tail[c][position]) + prod));
				end
				expected_codes.push_back(codes);
			end else begin
				for (int c = 0; c < CHANNELS; c++) begin
					prod = longint'($signed(s[c])) * w;
					tail[c][position - HALF_FRAME] = int'(clamp32(prod));
				end
			end
			position = (position + 1 == FRAME) ? 0 : position + 1;
		endfunction

		function void check_codes(dac_word_t got);
			dac_word_t want;
			if (expected_codes.size() == 0) begin
				$error("Result item arrived with none expected: %h", got);
				faults++;
				return;
			end
			want = expected_codes.pop_front();
			for (int c = 0; c < N_OUT; c++) begin
				if (got[c] !== want[c]) begin
					$error("dac_%0d: expected %0d, actual %0d", c, want[c], got[c]);
					faults++;
				end
			end
		endfunction

		function void close();
			if (expected_codes.size() != 0) begin
				$error("%0d expected result items never arrived", expected_codes.size());
				faults++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_write = 1'b0;
	logic [DAC_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [SAMPLE_W-1:0] sample_0 = '0;
	logic [SAMPLE_W-1:0] sample_1 = '0;
	logic [SAMPLE_W-1:0] sample_2 = '0;
	logic [SAMPLE_W-1:0] sample_3 = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [DAC_W-1:0]    dac_0;
	logic [DAC_W-1:0]    dac_1;
	logic [DAC_W-1:0]    dac_2;
	logic [DAC_W-1:0]    dac_3;

	hann_ola_predictor ola = new();
	int unsigned       burst_left = 0;

	overlap_add_hann_synthesis dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_0  (sample_0),
		.sample_1  (sample_1),
		.sample_2  (sample_2),
		.sample_3  (sample_3),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dac_0     (dac_0),
		.dac_1     (dac_1),
		.dac_2     (dac_2),
		.dac_3     (dac_3)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			ola.take_samples({sample_3, sample_2, sample_1, sample_0});
		end
		if (arst_n && out_valid && !out_stall) begin
			ola.check_codes({dac_3, dac_2, dac_1, dac_0});
		end
	end

	initial begin : receiver_pattern
		int unsigned mode;
		int unsigned span;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 60);
			for (int i = 0; i < span; i++) begin
				@(posedge clk);
				case (mode)
				0: begin
					out_stall <= 1'b0;
				end
				1: begin
					out_stall <= ($urandom_range(0, 1) == 1);
				end
				2: begin
					out_stall <= ($urandom_range(0, 7) == 0);
				end
				default: begin
					out_stall <= (i < 25);
				end
				endcase
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		do begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end while (quiet < QUIET_LIMIT);
		$display("Verification failed");
		$finish;
	end

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
		0: begin
			return 16'h7FFF;
		end
		1: begin
			return 16'h8000;
		end
		2: begin
			return ($urandom_range(0, 1) == 1) ? 16'h0001 : 16'hFFFF;
		end
		default: begin
			return 16'($urandom());
		end
		endcase
	endfunction

	task automatic drive_item(input sample_word_t s);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
		end
		in_valid <= 1'b1;
		sample_0 <= s[0];
		sample_1 <= s[1];
		sample_2 <= s[2];
		sample_3 <= s[3];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
	endtask

	// Holds the sender back until every expected item has come out and the
	// block has had time to finish any item that produces no result.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (ola.expected_codes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_midpoint(input logic [DAC_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		ola.set_midpoint(value);
	endtask

	initial begin : stimulus
		logic [DAC_W-1:0] midpoints [6];
		sample_word_t     s;
		midpoints = '{16'd32768, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd2048};
		midpoints[4] = 16'($urandom());
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 24; i++) begin
			for (int c = 0; c < N_OUT; c++) begin
				s[c] = EDGE_SAMPLES[(i + (i / 6 + 1) * c) % 6];
			end
			drive_item(s);
		end

		foreach (midpoints[k]) begin
			drain();
			write_midpoint(midpoints[k]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				for (int c = 0; c < N_OUT; c++) begin
					s[c] = pick_sample();
				end
				drive_item(s);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		ola.close();
		if (ola.faults == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/oahs_pkg.sv
rtl/core/oahs_ram.sv
rtl/core/oahs_lane.sv
rtl/core/overlap_add_hann_synthesis.sv
tb/sv/overlap_add_hann_synthesis_tb.sv
